[design/crc32rb_pkg.sv]
// ----------------------------------------------------------------------------
// crc32rb_pkg: shared types and constants of the reflected CRC-32 block engine
// Holds the polynomial, the block geometry, the control word that travels
// from the lane stage to the merge stage, and the elaboration-time functions
// that build the constant XOR matrices of the lanes and of the state path.
// ----------------------------------------------------------------------------
package crc32rb_pkg;

    // Block and CRC geometry.
    localparam int CRB_BLOCK_W = 128;
    localparam int CRB_CRC_W   = 32;
    localparam int CRB_LANES   = 4;

    // Reflected IEEE polynomial and the reset value of the CRC register.
    localparam logic [CRB_CRC_W-1:0] CRB_POLY = 32'hEDB88320;
    localparam logic [CRB_CRC_W-1:0] CRB_INIT = 32'hFFFFFFFF;

    typedef logic [CRB_CRC_W-1:0] crb_word_t;

    // Column j of a matrix is the CRC response to a one in input bit j.
    typedef logic [CRB_CRC_W-1:0][CRB_CRC_W-1:0]   crb_state_mat_t;
    typedef logic [CRB_BLOCK_W-1:0][CRB_CRC_W-1:0] crb_blk_mat_t;

    // Control word of an item held in the lane stage.
    typedef struct packed {
        logic      valid;
        logic      first;
        logic      last;
        crb_word_t seed;
    } crb_ctl_t;

    // Bit-serial reflected CRC over a whole block, LSB of the block first.
    // Only evaluated at elaboration to fill the constant matrices below.
    function automatic crb_word_t crb_feed(input crb_word_t c_in,
                                           input logic [CRB_BLOCK_W-1:0] blk);
        crb_word_t c;
        c = c_in;
        for (int i = 0; i < CRB_BLOCK_W; i++) begin
            c[0] = c[0] ^ blk[i];
            c    = c[0] ? ((c >> 1) ^ CRB_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Contribution of each block bit to the CRC, starting from a zero state.
    function automatic crb_blk_mat_t crb_block_matrix();
        crb_blk_mat_t m;
        for (int p = 0; p < CRB_BLOCK_W; p++) begin
            m[p] = crb_feed('0, CRB_BLOCK_W'(1) << p);
        end
        return m;
    endfunction

    // Effect of each state bit after a full block of zero data.
    function automatic crb_state_mat_t crb_state_matrix();
        crb_state_mat_t m;
        for (int j = 0; j < CRB_CRC_W; j++) begin
            m[j] = crb_feed(CRB_CRC_W'(1) << j, '0);
        end
        return m;
    endfunction

    // Multiply a state word by a constant 32x32 matrix over GF(2).
    function automatic crb_word_t crb_state_apply(input crb_state_mat_t m,
                                                  input crb_word_t x);
        crb_word_t acc;
        acc = '0;
        for (int j = 0; j < CRB_CRC_W; j++) begin
            if (x[j]) begin
                acc = acc ^ m[j];
            end
        end
        return acc;
    endfunction

endpackage

[design/crc32rb_lane.sv]
// ----------------------------------------------------------------------------
// crc32rb_lane: one slice of the block folded to a CRC contribution
// Each lane takes its share of the 128-bit block, multiplies it by the
// constant matrix that carries those bits through the rest of the block,
// and registers the 32-bit partial CRC for the merge stage.
// ----------------------------------------------------------------------------
module crc32rb_lane
    import crc32rb_pkg::*;
#(
    parameter int LANE_COUNT = CRB_LANES,
    parameter int LANE_IDX   = 0
) (
    input  logic                              aclk,
    input  logic                              load,
    input  logic [CRB_BLOCK_W/LANE_COUNT-1:0] data,
    output crb_word_t                         contrib
);

    localparam int LANE_W = CRB_BLOCK_W / LANE_COUNT;

    localparam crb_blk_mat_t BLK_MAT = crb_block_matrix();
    localparam logic [LANE_W-1:0][CRB_CRC_W-1:0] LANE_MAT =
        BLK_MAT[LANE_IDX*LANE_W +: LANE_W];

    crb_word_t contrib_reg;
    crb_word_t contrib_next;

    // XOR together the matrix columns of the set data bits.
    always_comb begin
        contrib_next = '0;
        for (int j = 0; j < LANE_W; j++) begin
            if (data[j]) begin
                contrib_next = contrib_next ^ LANE_MAT[j];
            end
        end
    end

    // Partial CRC register, loaded with every accepted word.
    always_ff @(posedge aclk) begin
        if (load) begin
            contrib_reg <= contrib_next;
        end
    end

    assign contrib = contrib_reg;

endmodule

[design/crc32rb_merge.sv]
// ----------------------------------------------------------------------------
// crc32rb_merge: lane merge, CRC state update and result register
// Combines the lane contributions with the running CRC carried across one
// block, updates the CRC register and holds the result word of a final
// block until the result channel takes it.
// ----------------------------------------------------------------------------
module crc32rb_merge
    import crc32rb_pkg::*;
#(
    parameter int LANE_COUNT = CRB_LANES
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  crb_ctl_t                          ctl,
    input  logic [LANE_COUNT-1:0][CRB_CRC_W-1:0] lane_crc,
    output logic                              adv,
    output logic                              m_valid,
    input  logic                              m_ready,
    output crb_word_t                         m_crc
);

    localparam crb_state_mat_t ST_MAT = crb_state_matrix();

    crb_word_t crc_reg;
    crb_word_t crc_next;
    crb_word_t lane_sum;
    crb_word_t base;
    logic      m_valid_reg;
    logic      m_valid_next;
    crb_word_t m_crc_reg;

    // A valid word moves on unless it is final and the result register is full and not being taken.
    assign adv = ctl.valid && (!ctl.last || !m_valid_reg || m_ready);

    // Sum of the lane contributions.
    always_comb begin
        lane_sum = '0;
        for (int i = 0; i < LANE_COUNT; i++) begin
            lane_sum = lane_sum ^ lane_crc[i];
        end
    end

    // Running CRC carried through the block, plus the data contribution.
    assign base     = ctl.first ? ctl.seed : crc_reg;
    assign crc_next = crb_state_apply(ST_MAT, base) ^ lane_sum;

    // Result valid flag: set by a final word, cleared when taken.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (adv && ctl.last) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // CRC state and result registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg     <= CRB_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (adv) begin
                crc_reg <= crc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && ctl.last) begin
            m_crc_reg <= crc_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_crc   = m_crc_reg;

endmodule

[design/crc32_reflected_block_update_top.sv]
// ----------------------------------------------------------------------------
// crc32_reflected_block_update_top: reflected CRC-32 over 16-byte blocks
//
//   Channel  Direction  Handshake            Word contents
//   s_       in         s_valid / s_ready    data_low, data_high, first, seed, last
//   m_       out        m_valid / m_ready    crc (register value, no final xor)
//
// One block is accepted every cycle while no final block waits. A result is
// valid once its final block has passed the lane registers, which take it on
// acceptance, and the merge stage has loaded the result register. The rate is
// set by the CRC register loop, a single 32x32 XOR matrix plus the lane sum
// per cycle. Reset is synchronous and active low; it empties the pipeline and
// loads the CRC register with all ones. Only a final block that finds the result
// register full and not taken waits; blocks behind it wait too, others flow on.
// ----------------------------------------------------------------------------
module crc32_reflected_block_update_top
    import crc32rb_pkg::*;
#(
    parameter int LANE_COUNT = CRB_LANES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_data_low,
    input  logic [63:0] s_data_high,
    input  logic        s_first,
    input  logic [31:0] s_seed,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_crc
);

    localparam int LANE_W = CRB_BLOCK_W / LANE_COUNT;

    logic [CRB_BLOCK_W-1:0]              block;
    logic [LANE_COUNT-1:0][CRB_CRC_W-1:0] lane_crc;
    crb_ctl_t                            ctl_reg;
    crb_ctl_t                            ctl_next;
    logic                                adv;

    // Byte 0 of the block sits in bits 7:0 and is absorbed first.
    assign block = {s_data_high, s_data_low};

    // The lane stage takes a word whenever it is empty or drains this cycle.
    assign s_ready = !ctl_reg.valid || adv;

    always_comb begin
        ctl_next = ctl_reg;
        if (s_ready) begin
            ctl_next.valid = s_valid;
            ctl_next.first = s_first;
            ctl_next.last  = s_last;
            ctl_next.seed  = s_seed;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg.valid <= 1'b0;
        end else begin
            ctl_reg <= ctl_next;
        end
    end

    // Lanes fold their slices of the block in parallel.
    for (genvar i = 0; i < LANE_COUNT; i++) begin : g_lane
        crc32rb_lane #(
            .LANE_COUNT (LANE_COUNT),
            .LANE_IDX   (i)
        ) u_lane (
            .aclk    (aclk),
            .load    (s_ready),
            .data    (block[i*LANE_W +: LANE_W]),
            .contrib (lane_crc[i])
        );
    end

    // Merge stage: state update and result register.
    crc32rb_merge #(
        .LANE_COUNT (LANE_COUNT)
    ) u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl_reg),
        .lane_crc (lane_crc),
        .adv      (adv),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_crc    (m_crc)
    );

`ifndef SYNTH
    // A final word never overwrites a result that is still waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !(adv && ctl_reg.last))
        else $error("final word advanced over a waiting result");

    // A final word that advances shows a result in the next cycle.
    a_last_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && ctl_reg.last) |=> m_valid)
        else $error("final word produced no result");

    // A held word in the lane stage blocks new input.
    a_hold_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl_reg.valid && !adv) |-> !s_ready)
        else $error("input accepted over a held word");

    // Reset empties the result register.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");
`endif

endmodule

[tb/tb_crc32_reflected_block_update_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_crc32_reflected_block_update_top: block-level test of the CRC-32 engine
// Feeds 16-byte words through the valid/ready input channel and checks every
// result word against a bytewise reflected CRC-32 calculation. The calculation
// runs in a scoreboard that tracks the running CRC register. Traffic starts
// with directed messages, then moves to randomized messages and loose words
// under several sender and receiver idle patterns. One long receiver hold-off
// makes the block back up and stall its input.
// ----------------------------------------------------------------------------
module tb_crc32_reflected_block_update_top;
    import crc32rb_pkg::*;

    // Tracks the CRC register and the queue of CRC values still to come out.
    class crc_scoreboard;
        crb_word_t crc_state;
        crb_word_t expected_crcs[$];
        int        failures;

        function new();
            crc_state = CRB_INIT;
            failures  = 0;
        endfunction

        // Runs one 16-byte word through the CRC, byte 0 of the low half first.
        function crb_word_t absorb_block(crb_word_t c, logic [63:0] lo, logic [63:0] hi);
            logic [127:0] blk;
            blk = {hi, lo};
            for (int n = 0; n < 16; n++) begin
                c = c ^ crb_word_t'(blk[8*n +: 8]);
                for (int k = 0; k < 8; k++) begin
                    c = c[0] ? ((c >> 1) ^ CRB_POLY) : (c >> 1);
                end
            end
            return c;
        endfunction

        // Updates the register for an accepted word and queues its result, if any.
        function void note_block(logic [63:0] lo, logic [63:0] hi, logic first,
                                 crb_word_t seed, logic last);
            crc_state = absorb_block(first ? seed : crc_state, lo, hi);
            if (last) begin
                expected_crcs.push_back(crc_state);
            end
        endfunction

        // Compares a result word with the oldest expected CRC.
        function void check_crc(crb_word_t actual);
            crb_word_t want;
            if (expected_crcs.size() == 0) begin
                $error("crc: unexpected result, actual %h", actual);
                failures++;
                return;
            end
            want = expected_crcs.pop_front();
            if (actual !== want) begin
                $error("crc: expected %h, actual %h", want, actual);
                failures++;
            end
        endfunction

        function int pending();
            return expected_crcs.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [63:0] s_data_low;
    logic [63:0] s_data_high;
    logic        s_first;
    logic [31:0] s_seed;
    logic        s_last;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_crc;

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int hold_request  = 0;

    crc_scoreboard sb = new();

    crc32_reflected_block_update_top dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data_low (s_data_low),
        .s_data_high(s_data_high),
        .s_first    (s_first),
        .s_seed     (s_seed),
        .s_last     (s_last),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_crc      (m_crc)
    );

    // Free-running clock, 20 ns period.
    initial begin
        aclk = 1'b0;
    end
    always #10 aclk = ~aclk;

    // Receiver: random ready, or a long hold-off when one is requested.
    initial begin : sink_proc
        int stall_left;
        stall_left = 0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request > 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0) begin
                m_ready = 1'b0;
                stall_left--;
            end else begin
                m_ready = ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Every result word that is taken goes to the scoreboard.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_crc(m_crc);
        end
    end

    // Random 64-bit half, with all-zero and all-one halves mixed in.
    function automatic logic [63:0] rand_half();
        case ($urandom_range(15))
            0:       return 64'h0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Offers one word, after a random idle gap, and holds it until it is taken.
    task automatic send_block(input logic [63:0] lo, input logic [63:0] hi,
                              input logic first, input crb_word_t seed, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid     = 1'b1;
        s_data_low  = lo;
        s_data_high = hi;
        s_first     = first;
        s_seed      = seed;
        s_last      = last;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        sb.note_block(lo, hi, first, seed, last);
        @(negedge aclk);
    endtask

    // Mostly well-formed messages of random length, with some loose words.
    task automatic run_random(input int target);
        int        sent;
        int        nblk;
        crb_word_t msg_seed;
        sent = 0;
        while (sent < target) begin
            if ($urandom_range(99) < 85) begin
                nblk     = ($urandom_range(9) == 0) ? $urandom_range(8, 24)
                                                    : $urandom_range(1, 4);
                msg_seed = ($urandom_range(2) == 0) ? crb_word_t'($urandom) : CRB_INIT;
                for (int b = 0; b < nblk; b++) begin
                    send_block(rand_half(), rand_half(), b == 0,
                               (b == 0) ? msg_seed : crb_word_t'($urandom),
                               b == nblk - 1);
                end
                sent += nblk;
            end else begin
                send_block(rand_half(), rand_half(), 1'($urandom_range(1)),
                           crb_word_t'($urandom), 1'($urandom_range(1)));
                sent++;
            end
        end
    endtask

    // Main sequence.
    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data_low  = '0;
        s_data_high = '0;
        s_first     = 1'b0;
        s_seed      = '0;
        s_last      = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed words. The first one continues from the reset value.
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        send_block(64'h0, 64'h0, 1'b0, 32'h1234_5678, 1'b1);
        send_block(64'h0, 64'h0, 1'b1, 32'hFFFF_FFFF, 1'b1);
        send_block('1, '1, 1'b1, 32'h0, 1'b1);
        send_block(64'h0, 64'h0, 1'b1, 32'h0, 1'b1);
        send_block('1, '1, 1'b1, 32'hFFFF_FFFF, 1'b1);
        send_block(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b1,
                   32'hAAAA_AAAA, 1'b1);
        send_block(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1,
                   32'h5555_5555, 1'b1);
        // A three-word message with the seed ignored on the later words.
        send_block(64'h3837_3635_3433_3231, 64'h4645_4443_4241_3039, 1'b1,
                   32'hFFFF_FFFF, 1'b0);
        send_block(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1'b0,
                   32'h0, 1'b0);
        send_block(64'h8000_0000_0000_0001, 64'h0000_0001_8000_0000, 1'b0,
                   32'hFFFF_FFFF, 1'b1);
        // Chaining onto the emitted value after a last word.
        send_block(64'hDEAD_BEEF_CAFE_F00D, 64'h0, 1'b0, 32'hFFFF_FFFF, 1'b1);
        send_block('1, 64'h0, 1'b0, 32'h0, 1'b0);
        send_block(64'h0, '1, 1'b0, 32'hA5A5_5A5A, 1'b1);
        // A first word in the middle of a message restarts it.
        send_block(64'h1111_2222_3333_4444, 64'h5555_6666_7777_8888, 1'b1,
                   32'hFFFF_FFFF, 1'b0);
        send_block(64'h9999_AAAA_BBBB_CCCC, 64'hDDDD_EEEE_FFFF_0000, 1'b1,
                   32'h0F0F_F0F0, 1'b0);
        send_block(64'h0, 64'h0, 1'b0, 32'h0, 1'b1);

        // Random traffic, sender idles 30% and receiver 75%.
        src_idle_pct  = 30;
        sink_idle_pct = 75;
        run_random(500);

        // Random traffic, sender idles 75% and receiver 30%.
        src_idle_pct  = 75;
        sink_idle_pct = 30;
        run_random(500);

        // Long receiver hold-off while one-word messages keep arriving.
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        s_valid       = 1'b0;
        @(posedge aclk);
        hold_request = 300;
        @(negedge aclk);
        for (int i = 0; i < 40; i++) begin
            send_block(rand_half(), rand_half(), 1'b1, crb_word_t'($urandom), 1'b1);
        end

        // Random traffic at full rate.
        run_random(500);

        // Drain the remaining results and let the pipeline settle.
        s_valid = 1'b0;
        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (20) @(posedge aclk);
        if (sb.failures == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
